// ===== hw/rtl/rvdiv_pkg.sv =====
// Shared types and constants for the RV32M divide/remainder unit.
// No dependencies; used by rvdiv_step and rv32m_divide_remainder_unit_core.
`default_nettype none

package rvdiv_pkg;

  localparam int unsigned DataWidth    = 32;
  localparam int unsigned PhysRegCount = 128;
  localparam int unsigned RobDepth     = 128;

  typedef enum logic [1:0] {
    OP_DIV  = 2'd0,
    OP_DIVU = 2'd1,
    OP_REM  = 2'd2,
    OP_REMU = 2'd3
  } op_e;

  // Control bits that ride along the divider stages
  typedef struct packed {
    logic is_rem;   // select remainder instead of quotient
    logic neg_res;  // negate the magnitude result at the end
    logic uop_en;   // slot holds a real micro-op
    logic flush;    // result killed
    logic fb_en;    // register file feedback write
  } meta_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rvdiv_step.sv =====
// One radix-2 restoring divide step: shift in a dividend bit, trial subtract.
// Depends on rvdiv_pkg.
`default_nettype none

module rvdiv_step (
  input  wire logic [rvdiv_pkg::DataWidth-1:0] rem_i,
  input  wire logic [rvdiv_pkg::DataWidth-1:0] quo_i,
  input  wire logic [rvdiv_pkg::DataWidth-1:0] dvs_i,
  output logic      [rvdiv_pkg::DataWidth-1:0] rem_o,
  output logic      [rvdiv_pkg::DataWidth-1:0] quo_o
);

  localparam int unsigned DW = rvdiv_pkg::DataWidth;

  logic [DW:0] part;
  logic [DW:0] diff;
  logic        take;

  always_comb begin
    part  = {rem_i, quo_i[DW-1]};
    diff  = part - {1'b0, dvs_i};
    take  = !diff[DW];
    // partial remainder stays below the divisor, so the top bit drops out
    rem_o = take ? diff[DW-1:0] : part[DW-1:0];
    quo_o = {quo_i[DW-2:0], take};
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rv32m_divide_remainder_unit_core.sv =====
// Pipelined RV32M divider: entry stage, one restoring step per stage, output stage.
// The entry stage loads at the transfer edge, then come 32 step stages and the output stage.
// Throughput: one micro-op per cycle while wb_ready_i does not stall the output; the 32
// single-bit divide steps set the depth.
// Back-pressure collapses bubbles stage by stage, so empty stages still fill while
// the output waits. Reset clears only the stage valid bits. Depends on rvdiv_pkg, rvdiv_step.
`default_nettype none

module rv32m_divide_remainder_unit_core #(
  parameter int unsigned PHYS_REG_COUNT = rvdiv_pkg::PhysRegCount,
  parameter int unsigned ROB_DEPTH      = rvdiv_pkg::RobDepth
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [1:0]                            operation_i,
  input  wire logic [rvdiv_pkg::DataWidth-1:0]       dividend_i,
  input  wire logic [rvdiv_pkg::DataWidth-1:0]       divisor_i,
  input  wire logic                                  uop_enable_i,
  input  wire logic                                  uop_valid_i,
  input  wire logic                                  need_rename_i,
  input  wire logic                                  has_exception_i,
  input  wire logic [$clog2(PHYS_REG_COUNT)-1:0]     dest_phys_reg_i,
  input  wire logic [$clog2(ROB_DEPTH)-1:0]          rob_index_i,
  input  wire logic                                  flush_i,
  output logic                                       wb_valid_o,
  input  wire logic                                  wb_ready_i,
  output logic                                       out_valid_o,
  output logic      [rvdiv_pkg::DataWidth-1:0]       quotient_or_remainder_o,
  output logic                                       feedback_enable_o,
  output logic      [$clog2(PHYS_REG_COUNT)-1:0]     feedback_phys_reg_o,
  output logic      [$clog2(ROB_DEPTH)-1:0]          out_rob_index_o
);

  localparam int unsigned DW   = rvdiv_pkg::DataWidth;
  localparam int unsigned PhysW = $clog2(PHYS_REG_COUNT);
  localparam int unsigned RobW  = $clog2(ROB_DEPTH);
  localparam int unsigned Last  = DW + 1;  // output stage index

  // stage valid bits: 0 entry, 1..DW steps, DW+1 output
  logic [Last:0] vld_q, vld_d;
  logic [Last:0] rdy;

  logic [DW-1:0]         rem_q  [0:DW];
  logic [DW-1:0]         quo_q  [0:DW];
  logic [DW-1:0]         dvs_q  [0:DW];
  rvdiv_pkg::meta_t      meta_q [0:DW];
  logic [PhysW-1:0]      phys_q [0:DW];
  logic [RobW-1:0]       rob_q  [0:DW];

  // ---------------- handshake chain ----------------
  assign rdy[Last] = !vld_q[Last] || wb_ready_i;
  for (genvar k = 0; k < Last; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  always_comb begin
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int unsigned k = 1; k <= Last; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o = rdy[0];

  // ---------------- entry stage: magnitudes and sign handling ----------------
  rvdiv_pkg::op_e   op;
  logic             signed_op, sa, sb, div0;
  rvdiv_pkg::meta_t meta_d;
  logic [DW-1:0]    mag_a_d, mag_b_d;

  always_comb begin
    op        = rvdiv_pkg::op_e'(operation_i);
    signed_op = (op == rvdiv_pkg::OP_DIV) || (op == rvdiv_pkg::OP_REM);
    sa        = signed_op && dividend_i[DW-1];
    sb        = signed_op && divisor_i[DW-1];
    div0      = (divisor_i == '0);
    mag_a_d   = sa ? (~dividend_i + DW'(1)) : dividend_i;
    mag_b_d   = sb ? (~divisor_i + DW'(1)) : divisor_i;
    meta_d.is_rem  = (op == rvdiv_pkg::OP_REM) || (op == rvdiv_pkg::OP_REMU);
    // divide by zero keeps the all-ones quotient; remainder follows dividend sign
    meta_d.neg_res = meta_d.is_rem ? sa : ((sa ^ sb) && !div0);
    meta_d.uop_en  = uop_enable_i;
    meta_d.flush   = flush_i;
    meta_d.fb_en   = uop_enable_i && uop_valid_i && need_rename_i && !has_exception_i;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      rem_q[0]  <= '0;
      quo_q[0]  <= mag_a_d;
      dvs_q[0]  <= mag_b_d;
      meta_q[0] <= meta_d;
      phys_q[0] <= dest_phys_reg_i;
      rob_q[0]  <= rob_index_i;
    end
  end

  // ---------------- divide steps ----------------
  for (genvar k = 1; k <= DW; k++) begin : g_step
    logic [DW-1:0] rem_d, quo_d;

    rvdiv_step u_step (
      .rem_i (rem_q[k-1]),
      .quo_i (quo_q[k-1]),
      .dvs_i (dvs_q[k-1]),
      .rem_o (rem_d),
      .quo_o (quo_d)
    );

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vld_q[k-1]) begin
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        dvs_q[k]  <= dvs_q[k-1];
        meta_q[k] <= meta_q[k-1];
        phys_q[k] <= phys_q[k-1];
        rob_q[k]  <= rob_q[k-1];
      end
    end
  end

  // ---------------- output stage ----------------
  logic [DW-1:0]    mag_res, res_d;
  rvdiv_pkg::meta_t mo;

  logic             out_vld_q, fb_en_q;
  logic [DW-1:0]    res_q;
  logic [PhysW-1:0] fb_phys_q;
  logic [RobW-1:0]  rob_out_q;

  always_comb begin
    mo      = meta_q[DW];
    mag_res = mo.is_rem ? rem_q[DW] : quo_q[DW];
    res_d   = mo.neg_res ? (~mag_res + DW'(1)) : mag_res;
    if (!mo.uop_en || mo.flush) begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[Last] && vld_q[DW]) begin
      out_vld_q <= !mo.flush;
      res_q     <= res_d;
      fb_en_q   <= mo.fb_en && !mo.flush;
      fb_phys_q <= mo.flush ? '0 : phys_q[DW];
      rob_out_q <= mo.flush ? '0 : rob_q[DW];
    end
  end

  assign wb_valid_o              = vld_q[Last];
  assign out_valid_o             = out_vld_q;
  assign quotient_or_remainder_o = res_q;
  assign feedback_enable_o       = fb_en_q;
  assign feedback_phys_reg_o     = fb_phys_q;
  assign out_rob_index_o         = rob_out_q;

  // ---------------- assertions ----------------
  a_empty_entry_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> in_ready_o)
    else $error("entry stage empty but input not ready");

  a_flush_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wb_valid_o && !out_valid_o) |->
      (quotient_or_remainder_o == '0) && !feedback_enable_o)
    else $error("flushed result carries data");

  a_fb_needs_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wb_valid_o && feedback_enable_o) |-> out_valid_o)
    else $error("feedback raised on killed result");

  a_div0_no_neg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && (dvs_q[0] == '0) && !meta_q[0].is_rem) |-> !meta_q[0].neg_res)
    else $error("divide by zero quotient would be negated");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[DW] && !wb_valid_o) |=> wb_valid_o)
    else $error("last step result not moved to output stage");

endmodule

`default_nettype wire

// ===== tb/rv32m_divide_remainder_unit_core_test.sv =====
// Testbench for rv32m_divide_remainder_unit_core: directed corner cases, then random
// micro-ops with random gaps and back-pressure, checked against an in-bench predictor.
// Depends on rvdiv_pkg and the core RTL.
`timescale 1ns / 100ps

module rv32m_divide_remainder_unit_core_test;

  localparam int unsigned DataWidth   = rvdiv_pkg::DataWidth;
  localparam int unsigned PhysW       = $clog2(rvdiv_pkg::PhysRegCount);
  localparam int unsigned RobW        = $clog2(rvdiv_pkg::RobDepth);
  localparam int          PipeLatency = 33;
  localparam int          SettleCycles = PipeLatency + 8;
  localparam logic [DataWidth-1:0] AllOnes = '1;
  localparam logic [DataWidth-1:0] MinInt  = 32'h8000_0000;

  typedef struct {
    rvdiv_pkg::op_e       op;
    logic [DataWidth-1:0] dividend;
    logic [DataWidth-1:0] divisor;
    logic                 enable;
    logic                 valid;
    logic                 rename;
    logic                 excp;
    logic [PhysW-1:0]     phys;
    logic [RobW-1:0]      rob;
    logic                 flush;
  } uop_t;

  typedef struct {
    logic                 out_valid;
    logic [DataWidth-1:0] result;
    logic                 fb_en;
    logic [PhysW-1:0]     fb_reg;
    logic [RobW-1:0]      rob;
  } wb_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [1:0]           operation_i;
  logic [DataWidth-1:0] dividend_i;
  logic [DataWidth-1:0] divisor_i;
  logic                 uop_enable_i;
  logic                 uop_valid_i;
  logic                 need_rename_i;
  logic                 has_exception_i;
  logic [PhysW-1:0]     dest_phys_reg_i;
  logic [RobW-1:0]      rob_index_i;
  logic                 flush_i;
  logic                 wb_valid_o;
  logic                 wb_ready_i;
  logic                 out_valid_o;
  logic [DataWidth-1:0] quotient_or_remainder_o;
  logic                 feedback_enable_o;
  logic [PhysW-1:0]     feedback_phys_reg_o;
  logic [RobW-1:0]      out_rob_index_o;

  rv32m_divide_remainder_unit_core dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid_i),
    .in_ready_o              (in_ready_o),
    .operation_i             (operation_i),
    .dividend_i              (dividend_i),
    .divisor_i               (divisor_i),
    .uop_enable_i            (uop_enable_i),
    .uop_valid_i             (uop_valid_i),
    .need_rename_i           (need_rename_i),
    .has_exception_i         (has_exception_i),
    .dest_phys_reg_i         (dest_phys_reg_i),
    .rob_index_i             (rob_index_i),
    .flush_i                 (flush_i),
    .wb_valid_o              (wb_valid_o),
    .wb_ready_i              (wb_ready_i),
    .out_valid_o             (out_valid_o),
    .quotient_or_remainder_o (quotient_or_remainder_o),
    .feedback_enable_o       (feedback_enable_o),
    .feedback_phys_reg_o     (feedback_phys_reg_o),
    .out_rob_index_o         (out_rob_index_o)
  );

  wb_t pending_wb[$];
  wb_t head_wb;
  int  errors = 0;
  bit  no_idle = 1'b0;
  int  uops_sent = 0;
  int  flushed_sent = 0;
  int  div_zero_sent = 0;
  int  overflow_sent = 0;
  int  op_seen[4] = '{0, 0, 0, 0};

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #400000;
    $display("timeout at %0t, %0d writebacks outstanding", $time, pending_wb.size());
    $display("TB_ERROR");
    $finish;
  end

  // RV32M quotient/remainder with the divide-by-zero and overflow rules applied
  function automatic wb_t predict_writeback(input uop_t u);
    wb_t                  w;
    logic [DataWidth-1:0] mag_a;
    logic [DataWidth-1:0] mag_b;
    logic [DataWidth-1:0] mag_r;
    logic [DataWidth-1:0] res;
    logic                 ovf;
    w = '{default: '0};
    if (u.flush) return w;
    ovf   = (u.dividend == MinInt) && (u.divisor == AllOnes);
    mag_a = u.dividend[DataWidth-1] ? -u.dividend : u.dividend;
    mag_b = u.divisor[DataWidth-1] ? -u.divisor : u.divisor;
    case (u.op)
      rvdiv_pkg::OP_DIV: begin
        if (u.divisor == '0) res = AllOnes;
        else if (ovf) res = MinInt;
        else begin
          mag_r = mag_a / mag_b;
          res = (u.dividend[DataWidth-1] != u.divisor[DataWidth-1]) ? -mag_r : mag_r;
        end
      end
      rvdiv_pkg::OP_DIVU: res = (u.divisor == '0) ? AllOnes : u.dividend / u.divisor;
      rvdiv_pkg::OP_REM: begin
        if (u.divisor == '0) res = u.dividend;
        else if (ovf) res = '0;
        else begin
          mag_r = mag_a % mag_b;
          res = u.dividend[DataWidth-1] ? -mag_r : mag_r;
        end
      end
      default: res = (u.divisor == '0) ? u.dividend : u.dividend % u.divisor;
    endcase
    w.out_valid = 1'b1;
    w.result    = u.enable ? res : '0;
    w.fb_en     = u.enable && u.valid && u.rename && !u.excp;
    w.fb_reg    = u.phys;
    w.rob       = u.rob;
    return w;
  endfunction

  function automatic uop_t make_uop(input rvdiv_pkg::op_e op,
                                    input logic [DataWidth-1:0] a,
                                    input logic [DataWidth-1:0] b);
    uop_t u;
    u.op       = op;
    u.dividend = a;
    u.divisor  = b;
    u.enable   = 1'b1;
    u.valid    = 1'b1;
    u.rename   = 1'b1;
    u.excp     = 1'b0;
    u.phys     = PhysW'($urandom);
    u.rob      = RobW'($urandom);
    u.flush    = 1'b0;
    return u;
  endfunction

  // operands lean toward the values where the special rules kick in
  function automatic logic [DataWidth-1:0] pick_operand();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 32'd1;
      2:       return AllOnes;
      3:       return MinInt;
      4:       return MinInt - 1;
      5:       return DataWidth'($urandom_range(0, 15));
      6:       return -DataWidth'($urandom_range(1, 15));
      7:       return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic uop_t random_uop();
    uop_t u;
    u = make_uop(rvdiv_pkg::op_e'($urandom_range(0, 3)), pick_operand(), pick_operand());
    if ($urandom_range(0, 19) == 0) begin
      u.dividend = MinInt;
      u.divisor  = AllOnes;
    end
    u.enable = ($urandom_range(0, 9) != 0);
    u.valid  = ($urandom_range(0, 7) != 0);
    u.rename = ($urandom_range(0, 3) != 0);
    u.excp   = ($urandom_range(0, 7) == 0);
    u.flush  = ($urandom_range(0, 9) == 0);
    return u;
  endfunction

  // one input transfer; returns at the edge that accepted it, valid still high
  task automatic send_uop(input uop_t u);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= u.op;
    dividend_i      <= u.dividend;
    divisor_i       <= u.divisor;
    uop_enable_i    <= u.enable;
    uop_valid_i     <= u.valid;
    need_rename_i   <= u.rename;
    has_exception_i <= u.excp;
    dest_phys_reg_i <= u.phys;
    rob_index_i     <= u.rob;
    flush_i         <= u.flush;
    do @(posedge clk_i); while (!in_ready_o);
    pending_wb.push_back(predict_writeback(u));
    uops_sent++;
    op_seen[u.op]++;
    if (u.flush) flushed_sent++;
    else if (u.enable && u.divisor == '0) div_zero_sent++;
    else if (u.enable && u.dividend == MinInt && u.divisor == AllOnes && !u.op[0])
      overflow_sent++;
  endtask

  // stop sending and wait for every outstanding writeback
  task automatic drain_writebacks();
    in_valid_i <= 1'b0;
    while (pending_wb.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_corners();
    uop_t u;
    for (int op = 0; op < 4; op++) begin
      send_uop(make_uop(rvdiv_pkg::op_e'(op), MinInt, AllOnes));
      send_uop(make_uop(rvdiv_pkg::op_e'(op), AllOnes, '0));
      send_uop(make_uop(rvdiv_pkg::op_e'(op), 32'h7FFF_FFFF, MinInt));
      send_uop(make_uop(rvdiv_pkg::op_e'(op), -32'd7, 32'd2));
    end
    // disabled slot: result zero, tags pass through
    u = make_uop(rvdiv_pkg::OP_DIVU, AllOnes, 32'd3);
    u.enable = 1'b0;
    u.phys   = '1;
    u.rob    = '1;
    send_uop(u);
    // enabled but not valid: result computed, no feedback
    u = make_uop(rvdiv_pkg::OP_REM, 32'd100, -32'd7);
    u.valid = 1'b0;
    u.phys  = '0;
    u.rob   = '0;
    send_uop(u);
    u = make_uop(rvdiv_pkg::OP_DIV, 32'd100, 32'd7);
    u.excp = 1'b1;
    send_uop(u);
    u = make_uop(rvdiv_pkg::OP_REMU, 32'd100, 32'd7);
    u.rename = 1'b0;
    send_uop(u);
    // flush zeroes every field
    u = make_uop(rvdiv_pkg::OP_DIV, AllOnes, 32'd1);
    u.flush = 1'b1;
    u.phys  = '1;
    u.rob   = '1;
    send_uop(u);
    send_uop(make_uop(rvdiv_pkg::OP_DIVU, '0, AllOnes));
    drain_writebacks();
  endtask

  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) send_uop(random_uop());
    drain_writebacks();
  endtask

  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    for (int i = 0; i < count; i++) send_uop(random_uop());
    drain_writebacks();
    no_idle = 1'b0;
  endtask

  task automatic test_bursts_with_pause(input int bursts, input int burst_len);
    for (int b = 0; b < bursts; b++) begin
      for (int i = 0; i < burst_len; i++) send_uop(random_uop());
      drain_writebacks();
    end
  endtask

  task automatic check_field(input string name, input logic [DataWidth-1:0] exp_v,
                             input logic [DataWidth-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && wb_valid_o && wb_ready_i) begin
      if (pending_wb.size() == 0) begin
        errors++;
        $display("%0t: writeback transfer with nothing outstanding, expected none, got rob 0x%02h",
                 $time, out_rob_index_o);
      end else begin
        head_wb = pending_wb.pop_front();
        check_field("out_valid", DataWidth'(head_wb.out_valid), DataWidth'(out_valid_o));
        check_field("quotient_or_remainder", head_wb.result, quotient_or_remainder_o);
        check_field("feedback_enable", DataWidth'(head_wb.fb_en),
                    DataWidth'(feedback_enable_o));
        check_field("feedback_phys_reg", DataWidth'(head_wb.fb_reg),
                    DataWidth'(feedback_phys_reg_o));
        check_field("out_rob_index", DataWidth'(head_wb.rob), DataWidth'(out_rob_index_o));
      end
    end
  end

  // writeback side: random stall before each transfer, except in the back-to-back test
  initial begin
    int stall;
    wb_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        wb_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      wb_ready_i <= 1'b1;
      do @(posedge clk_i); while (!wb_valid_o);
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    operation_i     <= rvdiv_pkg::OP_DIV;
    dividend_i      <= '0;
    divisor_i       <= '0;
    uop_enable_i    <= 1'b0;
    uop_valid_i     <= 1'b0;
    need_rename_i   <= 1'b0;
    has_exception_i <= 1'b0;
    dest_phys_reg_i <= '0;
    rob_index_i     <= '0;
    flush_i         <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_random_mix(550);
    test_back_to_back(150);
    test_bursts_with_pause(4, 25);

    repeat (SettleCycles) @(posedge clk_i);
    if (pending_wb.size() != 0) begin
      errors++;
      $display("%0t: writebacks missing, expected 0 outstanding, got %0d",
               $time, pending_wb.size());
    end
    $display("Sent %0d micro-ops (div %0d, divu %0d, rem %0d, remu %0d) under random stalls.",
             uops_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("Of these %0d flushed, %0d divide by zero, %0d signed overflow; %0d errors.",
             flushed_sent, div_zero_sent, overflow_sent, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
